### src/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GBFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GBFS_ASSERT(lbl, clk, rst_n, prop, msg)

`define GBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/gbfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbfs_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_QUEUE_DEPTH = 4096;

    localparam int COORD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 12;
    // wide enough for any grid size plus a wrapped neighbor coordinate
    localparam int SZ_W      = 9;

    localparam logic [STEP_W-1:0] STEP_MAX   = 12'hFFF;
    localparam logic [CFG_W-1:0]  SIZE_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 1'b0,
        CFG_GRID_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req_kind;

    // neighbor probe order: right, down, left, up
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    // two's complement offsets per direction
    localparam logic [1:0] DIR_DROW [4] = '{2'b00, 2'b01, 2'b00, 2'b11};
    localparam logic [1:0] DIR_DCOL [4] = '{2'b01, 2'b00, 2'b11, 2'b00};

    typedef enum logic [1:0] {
        RES_MISS = 2'd0,
        RES_ZERO = 2'd1,
        RES_HIT  = 2'd2
    } t_res_kind;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] row_or_start_row;
        logic [COORD_W-1:0] col_or_start_col;
        logic               cell_blocked;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [STEP_W-1:0] step_count;
    } t_res;

    typedef struct packed {
        logic      rclr;
        logic      cell_wr;
        logic      srch_ld;
        logic      st_rd;
        logic      push_start;
        logic      pop;
        logic      nb_rd;
        logic      push;
        logic      load_res;
        t_res_kind res_kind;
        logic      cln;
        t_dir      dir;
    } t_dp_cmd;

    typedef struct packed {
        logic rclr_done;
        logic st_fail;
        logic st_eq;
        logic q_empty;
        logic q_full;
        logic nb_in;
        logic nb_free;
        logic nb_goal;
        logic out_free;
        logic cln_done;
    } t_dp_sts;

endpackage

`default_nettype wire

### src/gbfs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbfs_req_if;
    logic           valid;
    logic           ready;
    gbfs_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gbfs_res_if;
    logic           valid;
    logic           ready;
    gbfs_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/gbfs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbfs_dpath #(
    parameter int MAX_ROWS    = gbfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = gbfs_pkg::DEF_MAX_COLS,
    parameter int QUEUE_DEPTH = gbfs_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gbfs_pkg::t_dp_cmd                 i_cmd,
    output gbfs_pkg::t_dp_sts                      o_sts,
    input  wire gbfs_pkg::t_req                    i_req_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [gbfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gbfs_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output gbfs_pkg::t_res                         o_out_data
);

    localparam int SZ_W   = gbfs_pkg::SZ_W;
    localparam int STEP_W = gbfs_pkg::STEP_W;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int QI_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = QI_W + 1;

    localparam logic [SZ_W-1:0]   ROWS_MAX = SZ_W'(MAX_ROWS);
    localparam logic [SZ_W-1:0]   COLS_MAX = SZ_W'(MAX_COLS);
    localparam logic [QC_W-1:0]   Q_CAP    = QC_W'(QUEUE_DEPTH);
    localparam logic [CELL_W-1:0] CELL_TOP = CELL_W'(CELLS - 1);

    typedef struct packed {
        logic [RW-1:0]     row;
        logic [CW-1:0]     col;
        logic [STEP_W-1:0] steps;
    } t_qent;

    function automatic logic [SZ_W-1:0] clamp_size(logic [gbfs_pkg::CFG_W-1:0] v,
                                                   logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(v);
        if (ext == '0) begin
            return SZ_W'(1);
        end
        if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

    function automatic logic [CELL_W-1:0] cell_idx(logic [RW-1:0] r, logic [CW-1:0] c);
        return CELL_W'(r) * CELL_W'(MAX_COLS) + CELL_W'(c);
    endfunction

    // grid size
    logic [SZ_W-1:0] r_rows, r_cols;

    // latched search request
    logic [gbfs_pkg::COORD_W-1:0] r_sr, r_sc, r_gr, r_gc;

    // storage
    logic  r_obs_mem   [CELLS];
    logic  r_vis_mem   [CELLS];
    t_qent r_queue_mem [QUEUE_DEPTH];

    logic  r_obs_rd, r_vis_rd;
    t_qent r_qrd;

    logic [QC_W-1:0]   r_head, r_tail, r_cidx;
    logic              r_cln_vld;
    logic [CELL_W-1:0] r_rclr;

    logic [RW-1:0]     r_nrow;
    logic [CW-1:0]     r_ncol;
    logic [CELL_W-1:0] r_nidx;

    logic           r_out_vld;
    gbfs_pkg::t_res r_out;

    logic [SZ_W-1:0]   w_wr_row, w_wr_col, w_sr, w_sc, w_gr, w_gc;
    logic              w_wr_in;
    logic [CELL_W-1:0] w_start_idx, w_cln_idx, w_rd_idx, w_nidx, w_vis_wa;
    logic [1:0]        w_drow, w_dcol;
    logic [SZ_W-1:0]   w_nr, w_nc;
    logic              w_nb_in;
    logic [STEP_W-1:0] w_nsteps;
    logic              w_q_full, w_out_free, w_cln_rd, w_q_rd, w_vis_we, w_q_we;
    logic [QI_W-1:0]   w_q_ra;
    t_qent             w_q_wd;

    always_comb begin
        w_wr_row = SZ_W'(i_req_data.row_or_start_row);
        w_wr_col = SZ_W'(i_req_data.col_or_start_col);
        w_wr_in  = (w_wr_row < ROWS_MAX) && (w_wr_col < COLS_MAX);

        w_sr = SZ_W'(r_sr);
        w_sc = SZ_W'(r_sc);
        w_gr = SZ_W'(r_gr);
        w_gc = SZ_W'(r_gc);
        w_start_idx = cell_idx(w_sr[RW-1:0], w_sc[CW-1:0]);

        w_drow = gbfs_pkg::DIR_DROW[i_cmd.dir];
        w_dcol = gbfs_pkg::DIR_DCOL[i_cmd.dir];
        // a step below zero wraps above any grid size
        w_nr = SZ_W'(r_qrd.row) + {{(SZ_W-2){w_drow[1]}}, w_drow};
        w_nc = SZ_W'(r_qrd.col) + {{(SZ_W-2){w_dcol[1]}}, w_dcol};
        w_nb_in = (w_nr < r_rows) && (w_nc < r_cols);
        w_nidx  = cell_idx(w_nr[RW-1:0], w_nc[CW-1:0]);

        w_rd_idx = i_cmd.st_rd ? w_start_idx : w_nidx;

        w_nsteps = (r_qrd.steps == gbfs_pkg::STEP_MAX) ? gbfs_pkg::STEP_MAX
                                                       : r_qrd.steps + 1'b1;

        w_q_full   = (r_tail == Q_CAP);
        w_out_free = !r_out_vld || i_out_ready;

        w_cln_rd = i_cmd.cln && (r_cidx != r_tail);
        w_q_rd   = i_cmd.pop || w_cln_rd;
        w_q_ra   = i_cmd.pop ? r_head[QI_W-1:0] : r_cidx[QI_W-1:0];

        w_q_we = i_cmd.push || i_cmd.push_start;
        if (i_cmd.push_start) begin
            w_q_wd = '{row: w_sr[RW-1:0], col: w_sc[CW-1:0], steps: '0};
        end else begin
            w_q_wd = '{row: r_nrow, col: r_ncol, steps: w_nsteps};
        end

        w_cln_idx = cell_idx(r_qrd.row, r_qrd.col);
        w_vis_we  = i_cmd.rclr || r_cln_vld || w_q_we;
        if (i_cmd.rclr) begin
            w_vis_wa = r_rclr;
        end else if (r_cln_vld) begin
            w_vis_wa = w_cln_idx;
        end else if (i_cmd.push_start) begin
            w_vis_wa = w_start_idx;
        end else begin
            w_vis_wa = r_nidx;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= clamp_size(gbfs_pkg::SIZE_RESET, ROWS_MAX);
            r_cols <= clamp_size(gbfs_pkg::SIZE_RESET, COLS_MAX);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbfs_pkg::CFG_GRID_ROWS: r_rows <= clamp_size(i_cfg_data, ROWS_MAX);
                gbfs_pkg::CFG_GRID_COLS: r_cols <= clamp_size(i_cfg_data, COLS_MAX);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_ld) begin
            r_sr <= i_req_data.row_or_start_row;
            r_sc <= i_req_data.col_or_start_col;
            r_gr <= i_req_data.goal_row;
            r_gc <= i_req_data.goal_col;
        end
        if (i_cmd.nb_rd) begin
            r_nrow <= w_nr[RW-1:0];
            r_ncol <= w_nc[CW-1:0];
            r_nidx <= w_nidx;
        end
    end

    // obstacle map
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_wr && w_wr_in) begin
            r_obs_mem[cell_idx(w_wr_row[RW-1:0], w_wr_col[CW-1:0])] <= i_req_data.cell_blocked;
        end
        if (i_cmd.st_rd || i_cmd.nb_rd) begin
            r_obs_rd <= r_obs_mem[w_rd_idx];
        end
    end

    // visited map
    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis_mem[w_vis_wa] <= w_q_we;
        end
        if (i_cmd.nb_rd) begin
            r_vis_rd <= r_vis_mem[w_nidx];
        end
    end

    // frontier queue
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_queue_mem[r_tail[QI_W-1:0]] <= w_q_wd;
        end
        if (w_q_rd) begin
            r_qrd <= r_queue_mem[w_q_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_cidx    <= '0;
            r_cln_vld <= 1'b0;
            r_rclr    <= '0;
        end else begin
            if (i_cmd.srch_ld) begin
                r_head <= '0;
                r_tail <= '0;
                r_cidx <= '0;
            end else begin
                if (i_cmd.pop) begin
                    r_head <= r_head + 1'b1;
                end
                if (w_q_we) begin
                    r_tail <= r_tail + 1'b1;
                end
                if (w_cln_rd) begin
                    r_cidx <= r_cidx + 1'b1;
                end
            end
            r_cln_vld <= w_cln_rd;
            if (i_cmd.rclr) begin
                r_rclr <= r_rclr + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_res) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            unique case (i_cmd.res_kind)
                gbfs_pkg::RES_HIT:  r_out <= '{found: 1'b1, step_count: w_nsteps};
                gbfs_pkg::RES_ZERO: r_out <= '{found: 1'b1, step_count: '0};
                default:            r_out <= '{found: 1'b0, step_count: '0};
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.rclr_done = (r_rclr == CELL_TOP);
        o_sts.st_fail   = (w_sr >= r_rows) || (w_sc >= r_cols) || (w_gr >= r_rows)
                          || (w_gc >= r_cols) || r_obs_rd;
        o_sts.st_eq     = (r_sr == r_gr) && (r_sc == r_gc);
        o_sts.q_empty   = (r_head == r_tail);
        o_sts.q_full    = w_q_full;
        o_sts.nb_in     = w_nb_in;
        o_sts.nb_free   = !r_vis_rd && !r_obs_rd;
        o_sts.nb_goal   = (SZ_W'(r_nrow) == w_gr) && (SZ_W'(r_ncol) == w_gc);
        o_sts.out_free  = w_out_free;
        o_sts.cln_done  = (r_cidx == r_tail) && !r_cln_vld;
    end

    `GBFS_ASSERT(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail, "queue head passed tail")
    `GBFS_ASSERT(a_push_room, i_clk, i_rst_n, !(w_q_we && w_q_full), "push into full queue")
    `GBFS_ASSERT(a_load_free, i_clk, i_rst_n, !(i_cmd.load_res && !w_out_free), "result overwritten")
    `GBFS_ASSERT_NEXT(a_pop_adv, i_clk, i_rst_n, i_cmd.pop && !i_cmd.srch_ld, r_head == $past(r_head) + 1'b1, "head did not advance")

endmodule

`default_nettype wire

### src/gbfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gbfs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_type,
    output logic                    o_req_ready,
    input  wire gbfs_pkg::t_dp_sts  i_sts,
    output gbfs_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_RCLR,
        S_IDLE,
        S_START,
        S_CHK,
        S_POP,
        S_PRB,
        S_EVAL,
        S_FIN,
        S_CLN
    } t_state;

    t_state               r_state, n_state;
    gbfs_pkg::t_dir       r_dir, n_dir, w_dir_nx;
    gbfs_pkg::t_res_kind  r_kind, n_kind;
    logic                 w_acc;

    always_comb begin
        unique case (r_dir)
            gbfs_pkg::DIR_RIGHT: w_dir_nx = gbfs_pkg::DIR_DOWN;
            gbfs_pkg::DIR_DOWN:  w_dir_nx = gbfs_pkg::DIR_LEFT;
            gbfs_pkg::DIR_LEFT:  w_dir_nx = gbfs_pkg::DIR_UP;
            default:             w_dir_nx = gbfs_pkg::DIR_RIGHT;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_dir   = r_dir;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.dir      = r_dir;
        o_cmd.res_kind = r_kind;
        o_req_ready = (r_state == S_IDLE);
        w_acc = i_req_valid && o_req_ready;

        unique case (r_state)
            S_RCLR: begin
                o_cmd.rclr = 1'b1;
                if (i_sts.rclr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req_type == gbfs_pkg::REQ_SEARCH) begin
                        o_cmd.srch_ld = 1'b1;
                        n_state = S_START;
                    end else begin
                        o_cmd.cell_wr = 1'b1;
                    end
                end
            end
            S_START: begin
                o_cmd.st_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.st_fail) begin
                    n_kind  = gbfs_pkg::RES_MISS;
                    n_state = S_FIN;
                end else if (i_sts.st_eq) begin
                    n_kind  = gbfs_pkg::RES_ZERO;
                    n_state = S_FIN;
                end else begin
                    o_cmd.push_start = 1'b1;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_kind  = gbfs_pkg::RES_MISS;
                    n_state = S_FIN;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_dir   = gbfs_pkg::DIR_RIGHT;
                    n_state = S_PRB;
                end
            end
            S_PRB: begin
                if (i_sts.nb_in) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state = S_EVAL;
                end else if (r_dir == gbfs_pkg::DIR_UP) begin
                    n_state = S_POP;
                end else begin
                    n_dir = w_dir_nx;
                end
            end
            S_EVAL: begin
                if (i_sts.nb_free && i_sts.nb_goal) begin
                    n_kind  = gbfs_pkg::RES_HIT;
                    n_state = S_FIN;
                end else begin
                    o_cmd.push = i_sts.nb_free && !i_sts.q_full;
                    if (r_dir == gbfs_pkg::DIR_UP) begin
                        n_state = S_POP;
                    end else begin
                        n_dir   = w_dir_nx;
                        n_state = S_PRB;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state = S_CLN;
                end
            end
            S_CLN: begin
                o_cmd.cln = 1'b1;
                if (i_sts.cln_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RCLR;
            r_dir   <= gbfs_pkg::DIR_RIGHT;
            r_kind  <= gbfs_pkg::RES_MISS;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

### src/grid_bfs_shortest_path.sv
// channel   dir   handshake          payload
// i_req     in    valid / ready      gbfs_pkg::t_req (cell write or search)
// o_res     out   valid / ready      gbfs_pkg::t_res (found, step_count)
// i_cfg     in    i_cfg_we           i_cfg_idx, i_cfg_data (grid_rows, grid_cols)
//
// cell write: no result transaction
// search: setup, then per dequeued cell a pop and a probe of each neighbor, with in-grid
// neighbors also read and evaluated, a miss if the queue runs empty, the result load
// and the clearing of the visited marks of every queued cell
// after reset the visited map is cleared, i_req.ready low
// a result waiting on o_res stalls the next search at its result load, not cell writes
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_shortest_path #(
    parameter int MAX_ROWS    = gbfs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = gbfs_pkg::DEF_MAX_COLS,
    parameter int QUEUE_DEPTH = gbfs_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    gbfs_req_if.sink                             i_req,
    gbfs_res_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [gbfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gbfs_pkg::CFG_W-1:0]      i_cfg_data
);

    gbfs_pkg::t_dp_cmd w_cmd;
    gbfs_pkg::t_dp_sts w_sts;
    logic              w_req_ready;

    assign i_req.ready = w_req_ready;

    gbfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.payload.req_type),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gbfs_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_data  (i_req.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_data  (o_res.payload)
    );

endmodule

`default_nettype wire
